// ===== design/position_hash_table_store_probe_macros.svh =====
// Assertion macros for the position hash table checker.
// No dependencies; included by the checker file only.
`ifndef POSITION_HASH_TABLE_STORE_PROBE_MACROS_SVH
`define POSITION_HASH_TABLE_STORE_PROBE_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define PHT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset.
`define PHT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pht_pkg.sv =====
// Shared types and constants for the position hash table.
// No dependencies; used by the top level, the score adjust unit and the checker.
package pht_pkg;

   localparam int DEF_INDEX_BITS = 16;
   localparam int DEF_MOVE_BITS  = 16;
   localparam int DEF_SCORE_BITS = 16;
   localparam int THRESH_W       = 15;
   localparam int ENTRY_W        = 17;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd30000;

   localparam logic [1:0] MODE_PROBE = 2'd0;
   localparam logic [1:0] MODE_STORE = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [1:0] NODE_EXACT = 2'd0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_CLEAR
   } pht_state_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [63:0]        key;
      logic [15:0]        best_move;
      logic [6:0]         root_depth;
      logic [6:0]         depth_searched;
      logic signed [15:0] score;
      logic [1:0]         node_type;
   } pht_req_type;

   typedef struct packed {
      logic                 hit;
      logic [15:0]          found_move;
      logic [6:0]           found_depth;
      logic signed [15:0]   found_score;
      logic [1:0]           found_type;
      logic                 written;
      logic [ENTRY_W-1:0]   entry_count;
   } pht_rsp_type;

endpackage

// ===== design/pht_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/pht_madj.sv =====
// Mate score adjustment by root depth, saturated to the stored score range.
// Depends on pht_pkg for the threshold width.
module pht_madj #(
   parameter int   IN_BITS    = 16,
   parameter int   SCORE_BITS = 16,
   parameter logic AWAY       = 1'b1
) (
   input  logic signed [IN_BITS-1:0]          score_i,
   input  logic [6:0]                         root_depth_i,
   input  logic [pht_pkg::THRESH_W-1:0]       threshold_i,
   output logic signed [SCORE_BITS-1:0]       score_o
);

   localparam int M1 = (IN_BITS > SCORE_BITS) ? IN_BITS : SCORE_BITS;
   localparam int M2 = (M1 > pht_pkg::THRESH_W + 1) ? M1 : pht_pkg::THRESH_W + 1;
   localparam int W  = M2 + 2;

   localparam logic signed [W-1:0] HI =
      {{(W-SCORE_BITS+1){1'b0}}, {(SCORE_BITS-1){1'b1}}};
   localparam logic signed [W-1:0] LO =
      {{(W-SCORE_BITS+1){1'b1}}, {(SCORE_BITS-1){1'b0}}};

   logic signed [W-1:0] s_w;
   logic signed [W-1:0] t_w;
   logic signed [W-1:0] d_w;
   logic signed [W-1:0] r_w;
   logic signed [W-1:0] c_w;

   assign s_w = W'(score_i);
   assign t_w = signed'({{(W-pht_pkg::THRESH_W){1'b0}}, threshold_i});
   assign d_w = AWAY ? signed'({{(W-7){1'b0}}, root_depth_i})
                     : -signed'({{(W-7){1'b0}}, root_depth_i});

   always_comb begin
      if (s_w <= -t_w) begin
         r_w = s_w - d_w;
      end else if (s_w >= t_w) begin
         r_w = s_w + d_w;
      end else begin
         r_w = s_w;
      end
      if (r_w > HI) begin
         c_w = HI;
      end else if (r_w < LO) begin
         c_w = LO;
      end else begin
         c_w = r_w;
      end
   end

   assign score_o = c_w[SCORE_BITS-1:0];

endmodule

// ===== design/position_hash_table_store_probe.sv =====
// Probe/store/unused items: accepted when start and !busy, busy in the lookup state,
// result strobed on rsp_strobe from a register loaded in that state; no new item is
// taken until the lookup ends, due to the registered read-modify-write of the slot RAM.
// Clear: sweeps all 2^INDEX_BITS slots of the RAM one slot a cycle, then strobes its result.
// Reset: the same clearing pass over all slots with busy high and no result;
// the mate score threshold returns to 30000. Configuration writes are always taken.
module position_hash_table_store_probe #(
   parameter int INDEX_BITS = pht_pkg::DEF_INDEX_BITS,
   parameter int MOVE_BITS  = pht_pkg::DEF_MOVE_BITS,
   parameter int SCORE_BITS = pht_pkg::DEF_SCORE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [63:0]                   req_key,
   input  logic [15:0]                   req_best_move,
   input  logic [6:0]                    req_root_depth,
   input  logic [6:0]                    req_depth_searched,
   input  logic signed [15:0]            req_score,
   input  logic [1:0]                    req_node_type,
   output logic                          rsp_strobe,
   output logic                          rsp_hit,
   output logic [15:0]                   rsp_found_move,
   output logic [6:0]                    rsp_found_depth,
   output logic signed [15:0]            rsp_found_score,
   output logic [1:0]                    rsp_found_type,
   output logic                          rsp_written,
   output logic [pht_pkg::ENTRY_W-1:0]   rsp_entry_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pht_pkg::THRESH_W-1:0]  csr_mate_bound
);

   localparam int DEPTH  = 1 << INDEX_BITS;
   localparam int PAY_W  = 9 + SCORE_BITS + MOVE_BITS;
   localparam int WORD_W = 64 + PAY_W;
   localparam int PX_W   = (PAY_W > 64) ? PAY_W : 64;
   localparam int CNT_W  = INDEX_BITS + 1;
   localparam int CNTX_W = (CNT_W > pht_pkg::ENTRY_W) ? CNT_W : pht_pkg::ENTRY_W;
   localparam int MVX_W  = (MOVE_BITS > 16) ? MOVE_BITS : 16;
   localparam int SCX_W  = (SCORE_BITS > 16) ? SCORE_BITS : 16;

   localparam logic [CNT_W-1:0] TABLE_FULL = {1'b1, {INDEX_BITS{1'b0}}};

   pht_pkg::pht_state_type          state_ff, state_in;
   pht_pkg::pht_req_type            req_ff, req_in;
   pht_pkg::pht_rsp_type            rsp_ff, rsp_in;
   logic                            rsp_strobe_ff, rsp_strobe_in;
   logic [INDEX_BITS-1:0]           clr_addr_ff, clr_addr_in;
   logic                            clr_rsp_ff, clr_rsp_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [pht_pkg::THRESH_W-1:0]    thresh_ff, thresh_in;

   logic                            wr_en;
   logic [INDEX_BITS-1:0]           wr_addr;
   logic [WORD_W-1:0]               wr_data;
   logic [WORD_W-1:0]               rd_data;

   logic [63:0]                     old_lock;
   logic [PAY_W-1:0]                old_pay;
   logic [PX_W-1:0]                 old_px;
   logic [1:0]                      old_ty;
   logic [6:0]                      old_dp;
   logic signed [SCORE_BITS-1:0]    old_sc;
   logic [MOVE_BITS-1:0]            old_mv;
   logic                            slot_hit;
   logic                            replace;
   logic signed [SCORE_BITS-1:0]    ret_sc;
   logic signed [SCORE_BITS-1:0]    sto_sc;
   logic [MVX_W-1:0]                mv_in_x;
   logic [MVX_W-1:0]                mv_old_x;
   logic [SCX_W-1:0]                sc_ret_x;
   logic [PAY_W-1:0]                new_pay;
   logic [PX_W-1:0]                 new_px;
   logic [63:0]                     new_lock;
   logic [CNT_W-1:0]                cnt_inc;
   logic [CNTX_W-1:0]               cnt_inc_x;
   logic [CNTX_W-1:0]               cnt_keep_x;

   pht_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (req_key[INDEX_BITS-1:0]),
      .rd_data (rd_data)
   );

   pht_madj #(
      .IN_BITS    (SCORE_BITS),
      .SCORE_BITS (SCORE_BITS),
      .AWAY       (1'b0)
   ) u_madj_ret (
      .score_i      (old_sc),
      .root_depth_i (req_ff.root_depth),
      .threshold_i  (thresh_ff),
      .score_o      (ret_sc)
   );

   pht_madj #(
      .IN_BITS    (16),
      .SCORE_BITS (SCORE_BITS),
      .AWAY       (1'b1)
   ) u_madj_sto (
      .score_i      (req_ff.score),
      .root_depth_i (req_ff.root_depth),
      .threshold_i  (thresh_ff),
      .score_o      (sto_sc)
   );

   // slot decode and match
   assign old_lock = rd_data[WORD_W-1:PAY_W];
   assign old_pay  = rd_data[PAY_W-1:0];
   assign old_px   = PX_W'(old_pay);
   assign old_ty   = old_pay[1:0];
   assign old_dp   = old_pay[8:2];
   assign old_sc   = signed'(old_pay[8+SCORE_BITS:9]);
   assign old_mv   = old_pay[PAY_W-1:9+SCORE_BITS];
   assign slot_hit = (old_lock != '0) && (old_lock == (req_ff.key ^ old_px[63:0]));
   assign replace  = !slot_hit ||
                     ((req_ff.node_type == pht_pkg::NODE_EXACT) &&
                      (old_ty != pht_pkg::NODE_EXACT) &&
                      (old_dp <= req_ff.depth_searched));

   // new slot contents
   assign mv_in_x  = MVX_W'(req_ff.best_move);
   assign new_pay  = {mv_in_x[MOVE_BITS-1:0], sto_sc, req_ff.depth_searched, req_ff.node_type};
   assign new_px   = PX_W'(new_pay);
   assign new_lock = req_ff.key ^ new_px[63:0];

   assign mv_old_x   = MVX_W'(old_mv);
   assign sc_ret_x   = SCX_W'(ret_sc);
   assign cnt_inc    = (count_ff == TABLE_FULL) ? count_ff : count_ff + 1'b1;
   assign cnt_inc_x  = CNTX_W'(cnt_inc);
   assign cnt_keep_x = CNTX_W'(count_ff);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      clr_addr_in   = clr_addr_ff;
      clr_rsp_in    = clr_rsp_ff;
      count_in      = count_ff;
      thresh_in     = (csr_valid && csr_ready) ? csr_mate_bound : thresh_ff;
      wr_en         = 1'b0;
      wr_addr       = req_ff.key[INDEX_BITS-1:0];
      wr_data       = {new_lock, new_pay};

      case (state_ff)
         pht_pkg::ST_IDLE: begin
            if (start) begin
               req_in.mode           = req_mode;
               req_in.key            = req_key;
               req_in.best_move      = req_best_move;
               req_in.root_depth     = req_root_depth;
               req_in.depth_searched = req_depth_searched;
               req_in.score          = req_score;
               req_in.node_type      = req_node_type;
               if (req_mode == pht_pkg::MODE_CLEAR) begin
                  state_in    = pht_pkg::ST_CLEAR;
                  clr_addr_in = '0;
                  clr_rsp_in  = 1'b1;
                  count_in    = '0;
               end else begin
                  state_in = pht_pkg::ST_LOOKUP;
               end
            end
         end
         pht_pkg::ST_LOOKUP: begin
            state_in           = pht_pkg::ST_IDLE;
            rsp_strobe_in      = 1'b1;
            rsp_in             = '0;
            rsp_in.entry_count = cnt_keep_x[pht_pkg::ENTRY_W-1:0];
            case (req_ff.mode)
               pht_pkg::MODE_PROBE: begin
                  if (slot_hit) begin
                     rsp_in.hit         = 1'b1;
                     rsp_in.found_move  = mv_old_x[15:0];
                     rsp_in.found_depth = old_dp;
                     rsp_in.found_score = signed'(sc_ret_x[15:0]);
                     rsp_in.found_type  = old_ty;
                  end
               end
               pht_pkg::MODE_STORE: begin
                  wr_en              = replace;
                  count_in           = cnt_inc;
                  rsp_in.hit         = slot_hit;
                  rsp_in.written     = replace;
                  rsp_in.entry_count = cnt_inc_x[pht_pkg::ENTRY_W-1:0];
               end
               default: begin
               end
            endcase
         end
         pht_pkg::ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in      = pht_pkg::ST_IDLE;
               rsp_strobe_in = clr_rsp_ff;
               rsp_in        = '0;
               clr_rsp_in    = 1'b0;
            end
         end
         default: begin
            state_in = pht_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pht_pkg::ST_CLEAR;
         rsp_strobe_ff <= 1'b0;
         clr_addr_ff   <= '0;
         clr_rsp_ff    <= 1'b0;
         count_ff      <= '0;
         thresh_ff     <= pht_pkg::THRESH_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         clr_addr_ff   <= clr_addr_in;
         clr_rsp_ff    <= clr_rsp_in;
         count_ff      <= count_in;
         thresh_ff     <= thresh_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy            = (state_ff != pht_pkg::ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_hit         = rsp_ff.hit;
   assign rsp_found_move  = rsp_ff.found_move;
   assign rsp_found_depth = rsp_ff.found_depth;
   assign rsp_found_score = rsp_ff.found_score;
   assign rsp_found_type  = rsp_ff.found_type;
   assign rsp_written     = rsp_ff.written;
   assign rsp_entry_count = rsp_ff.entry_count;

endmodule

// ===== design/pht_checker.sv =====
// Port-level checker for the position hash table, bound to the top level.
// Depends on pht_pkg and position_hash_table_store_probe_macros.svh.
`include "position_hash_table_store_probe_macros.svh"

module pht_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_strobe,
   input logic                         rsp_hit,
   input logic [15:0]                  rsp_found_move,
   input logic [6:0]                   rsp_found_depth,
   input logic signed [15:0]           rsp_found_score,
   input logic [1:0]                   rsp_found_type,
   input logic                         rsp_written,
   input logic [pht_pkg::ENTRY_W-1:0]  rsp_entry_count
);

   `PHT_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> busy, "no clearing pass after reset")

   `PHT_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accepted transaction did not raise busy")

   `PHT_ASSERT(a_strobe_gap, clock, reset, rsp_strobe |=> !rsp_strobe, "back-to-back result strobes")

   `PHT_ASSERT(a_miss_zero, clock, reset, (rsp_strobe && !rsp_hit) |-> (rsp_found_move == 16'd0 && rsp_found_depth == 7'd0 && rsp_found_score == 16'sd0 && rsp_found_type == 2'd0), "payload on a result without hit")

   `PHT_ASSERT(a_write_count, clock, reset, (rsp_strobe && rsp_written) |-> (rsp_entry_count != '0 && rsp_found_move == 16'd0), "written transaction with zero count or payload")

endmodule

bind position_hash_table_store_probe pht_checker u_pht_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_hit         (rsp_hit),
   .rsp_found_move  (rsp_found_move),
   .rsp_found_depth (rsp_found_depth),
   .rsp_found_score (rsp_found_score),
   .rsp_found_type  (rsp_found_type),
   .rsp_written     (rsp_written),
   .rsp_entry_count (rsp_entry_count)
);

// ===== tb/position_hash_table_store_probe_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the position hash table: mirrors the slot table, predicts each
// probe, store and clear transaction and checks every strobed result. Uses pht_pkg.
module position_hash_table_store_probe_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [63:0]                   req_key,
   input  logic [15:0]                   req_best_move,
   input  logic [6:0]                    req_root_depth,
   input  logic [6:0]                    req_depth_searched,
   input  logic signed [15:0]            req_score,
   input  logic [1:0]                    req_node_type,
   input  logic                          rsp_strobe,
   input  logic                          rsp_hit,
   input  logic [15:0]                   rsp_found_move,
   input  logic [6:0]                    rsp_found_depth,
   input  logic signed [15:0]            rsp_found_score,
   input  logic [1:0]                    rsp_found_type,
   input  logic                          rsp_written,
   input  logic [pht_pkg::ENTRY_W-1:0]   rsp_entry_count,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [pht_pkg::THRESH_W-1:0]  csr_mate_bound,
   output int                            error_count,
   output int                            answers_outstanding
);

   localparam int TABLE_SLOTS = 1 << pht_pkg::DEF_INDEX_BITS;

   typedef struct packed {
      logic [63:0]        lock;
      logic [15:0]        move;
      logic [6:0]         depth;
      logic [15:0]        score;
      logic [1:0]         kind;
   } slot_type;

   slot_type                      slots [int unsigned];
   logic [pht_pkg::THRESH_W-1:0]  threshold_q;
   logic [pht_pkg::ENTRY_W-1:0]   store_total;
   pht_pkg::pht_rsp_type          answers_due [$];

   function automatic logic [15:0] mate_shift(int s, int rd, int dir);
      int t;
      int r;
      t = int'(threshold_q);
      if (s <= -t) r = s - dir * rd;
      else if (s >= t) r = s + dir * rd;
      else r = s;
      if (r > 32767) r = 32767;
      else if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   function automatic logic [63:0] payload_bits(slot_type e);
      return {23'b0, e.move, e.score, e.depth, e.kind};
   endfunction

   function automatic pht_pkg::pht_rsp_type table_access(pht_pkg::pht_req_type rq);
      pht_pkg::pht_rsp_type ans;
      slot_type    cur;
      slot_type    nxt;
      int unsigned idx;
      bit          matched;
      bit          replace;
      ans = '0;
      cur = '0;
      idx = int'(rq.key[pht_pkg::DEF_INDEX_BITS-1:0]);
      if (slots.exists(idx)) cur = slots[idx];
      matched = cur.lock != 64'd0 && cur.lock == (rq.key ^ payload_bits(cur));
      case (rq.mode)
         pht_pkg::MODE_PROBE: begin
            if (matched) begin
               ans.hit = 1'b1;
               ans.found_move = cur.move;
               ans.found_depth = cur.depth;
               ans.found_score = mate_shift(int'($signed(cur.score)), int'(rq.root_depth), -1);
               ans.found_type = cur.kind;
            end
         end
         pht_pkg::MODE_STORE: begin
            replace = !matched || (rq.node_type == pht_pkg::NODE_EXACT
                                   && cur.kind != pht_pkg::NODE_EXACT
                                   && cur.depth <= rq.depth_searched);
            if (replace) begin
               nxt.lock = '0;
               nxt.move = rq.best_move;
               nxt.depth = rq.depth_searched;
               nxt.score = mate_shift(int'(rq.score), int'(rq.root_depth), 1);
               nxt.kind = rq.node_type;
               nxt.lock = rq.key ^ payload_bits(nxt);
               slots[idx] = nxt;
            end
            if (store_total < TABLE_SLOTS) store_total = store_total + 1'b1;
            ans.hit = matched;
            ans.written = replace;
         end
         pht_pkg::MODE_CLEAR: begin
            slots.delete();
            store_total = '0;
         end
         default: ;
      endcase
      ans.entry_count = store_total;
      return ans;
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         error_count++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      pht_pkg::pht_req_type rq;
      pht_pkg::pht_rsp_type want;
      if (reset) begin
         slots.delete();
         store_total = '0;
         threshold_q = pht_pkg::THRESH_RESET;
         answers_due.delete();
         error_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (answers_due.size() == 0) begin
               error_count++;
               $error("result strobed with no transaction outstanding");
            end else begin
               want = answers_due.pop_front();
               compare_field("hit", 64'(want.hit), 64'(rsp_hit));
               compare_field("found_move", 64'(want.found_move), 64'(rsp_found_move));
               compare_field("found_depth", 64'(want.found_depth), 64'(rsp_found_depth));
               compare_field("found_score", 64'(want.found_score), 64'(rsp_found_score));
               compare_field("found_type", 64'(want.found_type), 64'(rsp_found_type));
               compare_field("written", 64'(want.written), 64'(rsp_written));
               compare_field("entry_count", 64'(want.entry_count), 64'(rsp_entry_count));
            end
         end
         if (csr_valid && csr_ready) threshold_q = csr_mate_bound;
         if (start && !busy) begin
            rq.mode = req_mode;
            rq.key = req_key;
            rq.best_move = req_best_move;
            rq.root_depth = req_root_depth;
            rq.depth_searched = req_depth_searched;
            rq.score = req_score;
            rq.node_type = req_node_type;
            answers_due.push_back(table_access(rq));
         end
      end
      answers_outstanding = answers_due.size();
   end

endmodule

// ===== tb/position_hash_table_store_probe_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the position hash table: clock, reset, threshold settings and
// probe/store/clear stimulus. Uses pht_pkg, the block and the checker module.
module position_hash_table_store_probe_tb;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0] NODE_LOWER  = 2'd1;
   localparam logic [1:0] NODE_UPPER  = 2'd2;
   localparam logic [1:0] NODE_ODD    = 2'd3;
   localparam int KEY_POOL    = 24;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [1:0]                    req_mode = '0;
   logic [63:0]                   req_key = '0;
   logic [15:0]                   req_best_move = '0;
   logic [6:0]                    req_root_depth = '0;
   logic [6:0]                    req_depth_searched = '0;
   logic signed [15:0]            req_score = '0;
   logic [1:0]                    req_node_type = '0;
   logic                          rsp_strobe;
   logic                          rsp_hit;
   logic [15:0]                   rsp_found_move;
   logic [6:0]                    rsp_found_depth;
   logic signed [15:0]            rsp_found_score;
   logic [1:0]                    rsp_found_type;
   logic                          rsp_written;
   logic [pht_pkg::ENTRY_W-1:0]   rsp_entry_count;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [pht_pkg::THRESH_W-1:0]  csr_mate_bound = '0;
   int                            error_count;
   int                            answers_outstanding;

   logic [63:0]                   key_pool [KEY_POOL];
   logic [pht_pkg::THRESH_W-1:0]  mate_limit;
   int                            clears_left;

   always #4 clock = ~clock;

   position_hash_table_store_probe DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_key(req_key), .req_best_move(req_best_move),
      .req_root_depth(req_root_depth), .req_depth_searched(req_depth_searched),
      .req_score(req_score), .req_node_type(req_node_type),
      .rsp_strobe(rsp_strobe), .rsp_hit(rsp_hit), .rsp_found_move(rsp_found_move),
      .rsp_found_depth(rsp_found_depth), .rsp_found_score(rsp_found_score),
      .rsp_found_type(rsp_found_type), .rsp_written(rsp_written),
      .rsp_entry_count(rsp_entry_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_mate_bound(csr_mate_bound)
   );

   position_hash_table_store_probe_checker lookup_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_key(req_key), .req_best_move(req_best_move),
      .req_root_depth(req_root_depth), .req_depth_searched(req_depth_searched),
      .req_score(req_score), .req_node_type(req_node_type),
      .rsp_strobe(rsp_strobe), .rsp_hit(rsp_hit), .rsp_found_move(rsp_found_move),
      .rsp_found_depth(rsp_found_depth), .rsp_found_score(rsp_found_score),
      .rsp_found_type(rsp_found_type), .rsp_written(rsp_written),
      .rsp_entry_count(rsp_entry_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_mate_bound(csr_mate_bound),
      .error_count(error_count), .answers_outstanding(answers_outstanding)
   );

   initial begin : watchdog
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   task automatic send(input logic [1:0] mode, input logic [63:0] key,
                       input logic [15:0] mv, input logic [6:0] rd, input logic [6:0] dp,
                       input logic signed [15:0] sc, input logic [1:0] ty);
      start = 1'b1;
      req_mode = mode;
      req_key = key;
      req_best_move = mv;
      req_root_depth = rd;
      req_depth_searched = dp;
      req_score = sc;
      req_node_type = ty;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic pause(input int pct);
      while ($urandom_range(99) < pct) begin
         start = 1'b0;
         req_mode = 2'($urandom);
         req_key = {$urandom, $urandom};
         req_score = 16'($urandom);
         @(negedge clock);
      end
   endtask

   task automatic quiesce();
      start = 1'b0;
      while (answers_outstanding != 0 || busy) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [pht_pkg::THRESH_W-1:0] value);
      quiesce();
      csr_valid = 1'b1;
      csr_mate_bound = value;
      while (!csr_ready) @(negedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      mate_limit = value;
   endtask

   function automatic logic signed [15:0] pick_score();
      int r;
      int s;
      r = $urandom_range(99);
      if (r < 40) begin
         s = int'(mate_limit) - 2 + int'($urandom_range(4));
         if ($urandom_range(1) == 1) s = -s;
         if (s > 32767) s = 32767;
         else if (s < -32768) s = -32768;
         return 16'(s);
      end
      if (r < 60) return ($urandom_range(1) == 1) ? 16'sh7FFF : 16'sh8000;
      return 16'($urandom);
   endfunction

   function automatic logic [6:0] pick_depth();
      if ($urandom_range(99) < 20) return ($urandom_range(1) == 1) ? 7'd127 : 7'd0;
      return 7'($urandom);
   endfunction

   // Episodes of stores and probes on one slot; a few noise transactions of any mode.
   task automatic run_random(input int count, input int pct);
      int                 done;
      int                 pick;
      int                 steps;
      bit                 zero_lock;
      logic [1:0]         mode;
      logic [63:0]        key;
      logic [15:0]        mv;
      logic [6:0]         dp;
      logic signed [15:0] sc;
      logic [1:0]         ty;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            mode = 2'($urandom);
            if (mode == pht_pkg::MODE_CLEAR) begin
               if (clears_left == 0) mode = pht_pkg::MODE_PROBE;
               else clears_left--;
            end
            send(mode, {$urandom, $urandom}, 16'($urandom), 7'($urandom), 7'($urandom),
                 16'($urandom), 2'($urandom));
            pause(pct);
            done++;
         end else begin
            mv = 16'($urandom);
            dp = pick_depth();
            sc = pick_score();
            ty = 2'($urandom);
            zero_lock = 1'b0;
            if (pick < 14) begin
               key = {23'b0, mv, sc, dp, ty};
               zero_lock = 1'b1;
            end else if (pick < 30) begin
               key = {$urandom, 16'($urandom),
                      key_pool[$urandom_range(KEY_POOL-1)][pht_pkg::DEF_INDEX_BITS-1:0]};
            end else if (pick < 40) begin
               key = {$urandom, $urandom};
            end else begin
               key = key_pool[$urandom_range(KEY_POOL-1)];
            end
            steps = $urandom_range(1, 4);
            for (int i = 0; i < steps; i++) begin
               mode = ($urandom_range(99) < 50) ? pht_pkg::MODE_STORE : pht_pkg::MODE_PROBE;
               if (i > 0 && $urandom_range(99) < 40) ty = 2'($urandom);
               if (i > 0 && $urandom_range(99) < 40) dp = pick_depth();
               send(mode, key, mv, zero_lock ? 7'd0 : pick_depth(), dp, sc, ty);
               pause(pct);
               done++;
            end
         end
      end
   endtask

   initial begin : stimulus
      logic [63:0] k1;
      logic [63:0] k2;
      logic [63:0] k3;
      logic [63:0] k0;
      k1 = 64'hA5A5_0000_0000_1234;
      k2 = 64'h5A5A_FFFF_0000_1234;
      k3 = 64'h0123_4567_89AB_0042;
      k0 = {23'b0, 16'h00AB, 16'sd1000, 7'd3, pht_pkg::NODE_EXACT};
      mate_limit = pht_pkg::THRESH_RESET;
      clears_left = 3;
      for (int i = 0; i < KEY_POOL; i++) begin
         key_pool[i] = {$urandom, $urandom};
         case (i % 8)
            0: key_pool[i][15:0] = 16'h0000;
            1: key_pool[i][15:0] = 16'hFFFF;
            default: key_pool[i][15:0] = 16'h1000 + 16'(i % 8);
         endcase
      end
      repeat (10) @(negedge clock);
      reset = 1'b0;

      send(pht_pkg::MODE_PROBE, 64'd0, 16'd0, 7'd0, 7'd0, 16'sd0, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_STORE, k1, 16'hFFFF, 7'd127, 7'd127, 16'sh7FFF, NODE_LOWER);
      send(pht_pkg::MODE_PROBE, k1, 16'd0, 7'd127, 7'd0, 16'sd0, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_STORE, k1, 16'h1357, 7'd1, 7'd127, 16'sd30000, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_STORE, k1, 16'h2468, 7'd0, 7'd0, 16'sd0, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_PROBE, k1, 16'd0, 7'd0, 7'd0, 16'sd0, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_STORE, k2, 16'h0000, 7'd127, 7'd64, 16'sh8000, NODE_UPPER);
      send(pht_pkg::MODE_PROBE, k2, 16'd0, 7'd127, 7'd0, 16'sd0, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_PROBE, k1, 16'd0, 7'd0, 7'd0, 16'sd0, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_STORE, k2, 16'h7777, 7'd3, 7'd127, 16'sd5, NODE_ODD);
      send(pht_pkg::MODE_STORE, k3, 16'h0F0F, 7'd50, 7'd0, -16'sd29999, NODE_ODD);
      send(pht_pkg::MODE_STORE, k3, 16'hF0F0, 7'd50, 7'd0, -16'sd30000, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_PROBE, k3, 16'd0, 7'd50, 7'd0, 16'sd0, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_PROBE, k3, 16'd0, 7'd127, 7'd0, 16'sd0, pht_pkg::NODE_EXACT);
      // lock word comes out zero: the slot still reads as empty
      send(pht_pkg::MODE_STORE, k0, 16'h00AB, 7'd0, 7'd3, 16'sd1000, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_PROBE, k0, 16'd0, 7'd0, 7'd0, 16'sd0, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_STORE, k0, 16'h00AB, 7'd0, 7'd3, 16'sd1000, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_STORE, '1, 16'h0000, 7'd127, 7'd0, 16'sd29999, NODE_UPPER);
      send(pht_pkg::MODE_PROBE, '1, 16'hFFFF, 7'd127, 7'd127, 16'sh7FFF, NODE_ODD);
      send(MODE_UNUSED, '1, 16'hFFFF, 7'd127, 7'd127, 16'sh8000, NODE_ODD);
      send(pht_pkg::MODE_PROBE, '1, 16'd0, 7'd0, 7'd0, 16'sd0, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_CLEAR, k2, 16'd0, 7'd0, 7'd0, 16'sd0, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_PROBE, k2, 16'd0, 7'd0, 7'd0, 16'sd0, pht_pkg::NODE_EXACT);
      send(pht_pkg::MODE_STORE, k1, 16'h0001, 7'd0, 7'd1, -16'sd30000, NODE_LOWER);
      send(pht_pkg::MODE_PROBE, k1, 16'd0, 7'd0, 7'd0, 16'sd0, pht_pkg::NODE_EXACT);

      write_threshold(15'd0);
      run_random(100, 0);
      write_threshold(15'h7FFF);
      run_random(100, 55);
      write_threshold(15'($urandom_range(1, 32766)));
      run_random(100, 25);
      write_threshold(pht_pkg::THRESH_RESET);
      run_random(100, 55);

      quiesce();
      repeat (8) @(negedge clock);
      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
